[hw/rtl/sss_pkg.sv]
// Shared types and constants for the sonar sweep scan controller.
package sss_pkg;

   localparam int unsigned ANGLE_BITS     = 8;
   localparam int unsigned PHASE_BITS     = 3;
   localparam int unsigned CSR_ADDR_BITS  = 5;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned DIST_LIMIT     = 999;

   // scan phases
   localparam logic [PHASE_BITS-1:0] PH_IDLE = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_PING = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_ECHO = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_MOVE = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_DONE = 3'd4;

   // request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes (byte address = 4 * index)
   localparam logic [CSR_INDEX_BITS-1:0] REG_SWEEP_STEP = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCAN_FROM  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCAN_TO    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ANGLE_LOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ANGLE_HIGH = 3'd4;

   typedef logic [ANGLE_BITS-1:0] angle_type;

   typedef struct packed {
      angle_type sweep_step;
      angle_type scan_from;
      angle_type scan_to;
      angle_type angle_low;
      angle_type angle_high;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      angle_type             ping_angle;
      angle_type             end_angle;
      angle_type             step_used;
      angle_type             angle_at_min;
      angle_type             angle_at_max;
   } state_type;

   typedef struct packed {
      logic      ping_fire;
      logic      target_valid;
      angle_type target_angle;
      logic      sensor_reset;
   } cmd_type;

endpackage

[hw/rtl/sss_req_if.sv]
// Request channel: scan start or sensor status tick.
interface sss_req_if #(
   parameter int unsigned DISTANCE_BITS = 10
);
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic                     sonar_ready;
   logic                     servo_settled;
   logic                     echo_valid;
   logic [DISTANCE_BITS-1:0] echo_distance;
   logic [7:0]               servo_angle;

   modport source (
      output valid, op, sonar_ready, servo_settled, echo_valid, echo_distance, servo_angle,
      input  ready
   );
   modport sink (
      input  valid, op, sonar_ready, servo_settled, echo_valid, echo_distance, servo_angle,
      output ready
   );
endinterface

[hw/rtl/sss_rsp_if.sv]
// Result channel: commands and scan status for one request.
interface sss_rsp_if #(
   parameter int unsigned DISTANCE_BITS = 10
);
   logic                     valid;
   logic                     ready;
   logic [2:0]               phase;
   logic                     ping_fire;
   logic                     target_valid;
   logic [7:0]               target_angle;
   logic                     sensor_reset;
   logic [DISTANCE_BITS-1:0] last_distance;
   logic [DISTANCE_BITS-1:0] min_distance;
   logic [7:0]               min_dist_angle;
   logic [DISTANCE_BITS-1:0] max_distance;
   logic [7:0]               max_dist_angle;
   logic                     scan_done;

   modport source (
      output valid, phase, ping_fire, target_valid, target_angle, sensor_reset,
             last_distance, min_distance, min_dist_angle, max_distance, max_dist_angle,
             scan_done,
      input  ready
   );
   modport sink (
      input  valid, phase, ping_fire, target_valid, target_angle, sensor_reset,
             last_distance, min_distance, min_dist_angle, max_distance, max_dist_angle,
             scan_done,
      output ready
   );
endinterface

[hw/rtl/sss_csr.sv]
// APB-style configuration registers of the scan controller.
module sss_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sss_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [sss_pkg::CSR_DATA_BITS-1:0]    prdata,
   output sss_pkg::cfg_type                     cfg
);
   import sss_pkg::*;

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic [CSR_INDEX_BITS-1:0] index;
   logic                      wr_en;
   angle_type                 wr_val;

   assign index  = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign wr_val = pwdata[ANGLE_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_SWEEP_STEP: cfg_in.sweep_step = wr_val;
            REG_SCAN_FROM:  cfg_in.scan_from  = wr_val;
            REG_SCAN_TO:    cfg_in.scan_to    = wr_val;
            REG_ANGLE_LOW:  cfg_in.angle_low  = wr_val;
            REG_ANGLE_HIGH: cfg_in.angle_high = wr_val;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SWEEP_STEP: prdata = CSR_DATA_BITS'(cfg_ff.sweep_step);
         REG_SCAN_FROM:  prdata = CSR_DATA_BITS'(cfg_ff.scan_from);
         REG_SCAN_TO:    prdata = CSR_DATA_BITS'(cfg_ff.scan_to);
         REG_ANGLE_LOW:  prdata = CSR_DATA_BITS'(cfg_ff.angle_low);
         REG_ANGLE_HIGH: prdata = CSR_DATA_BITS'(cfg_ff.angle_high);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_step <= ANGLE_BITS'(1);
         cfg_ff.scan_from  <= '0;
         cfg_ff.scan_to    <= '0;
         cfg_ff.angle_low  <= '0;
         cfg_ff.angle_high <= ANGLE_BITS'(180);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/sss_step.sv]
// One scan phase: next state and commands from the current state and a request.
module sss_step #(
   parameter int unsigned DISTANCE_BITS = 10
) (
   input  sss_pkg::cfg_type           cfg,
   input  sss_pkg::state_type         st,
   input  logic [DISTANCE_BITS-1:0]   dist_last,
   input  logic [DISTANCE_BITS-1:0]   dist_min,
   input  logic [DISTANCE_BITS-1:0]   dist_max,
   input  logic                       op,
   input  logic                       sonar_ready,
   input  logic                       servo_settled,
   input  logic                       echo_valid,
   input  logic [DISTANCE_BITS-1:0]   echo_distance,
   input  sss_pkg::angle_type         servo_angle,
   output sss_pkg::state_type         st_next,
   output logic [DISTANCE_BITS-1:0]   dist_last_next,
   output logic [DISTANCE_BITS-1:0]   dist_min_next,
   output logic [DISTANCE_BITS-1:0]   dist_max_next,
   output sss_pkg::cmd_type           cmd
);
   import sss_pkg::*;

   localparam int unsigned DIST_MASK = (1 << DISTANCE_BITS) - 1;
   localparam logic [DISTANCE_BITS-1:0] DIST_SAT =
      DISTANCE_BITS'((DIST_LIMIT < DIST_MASK) ? DIST_LIMIT : DIST_MASK);

   logic [DISTANCE_BITS-1:0] echo_sat;
   logic [ANGLE_BITS:0]      up_sum;
   logic [ANGLE_BITS:0]      down_floor;

   assign echo_sat   = (echo_distance > DIST_SAT) ? DIST_SAT : echo_distance;
   assign up_sum     = {1'b0, servo_angle} + {1'b0, st.step_used};
   assign down_floor = {1'b0, st.end_angle} + {1'b0, st.step_used};

   always_comb begin
      st_next        = st;
      dist_last_next = dist_last;
      dist_min_next  = dist_min;
      dist_max_next  = dist_max;
      cmd            = '0;

      if (op == OP_START) begin
         if (cfg.sweep_step == '0) begin
            // single point: keep previous step; clamp end angle, not the target
            priority if (cfg.scan_from < cfg.angle_low) begin
               st_next.end_angle = cfg.angle_low;
            end else if (cfg.scan_from > cfg.angle_high) begin
               st_next.end_angle = cfg.angle_high;
            end else begin
               st_next.end_angle = cfg.scan_from;
            end
            cmd.target_angle = cfg.scan_from;
         end else begin
            st_next.step_used = cfg.sweep_step;
            st_next.end_angle = (cfg.scan_to < cfg.angle_high) ? cfg.scan_to : cfg.angle_high;
            cmd.target_angle  = (cfg.scan_from > cfg.angle_low) ? cfg.scan_from : cfg.angle_low;
         end
         cmd.target_valid     = 1'b1;
         cmd.sensor_reset     = 1'b1;
         st_next.phase        = PH_PING;
         st_next.angle_at_min = '0;
         st_next.angle_at_max = '0;
         dist_min_next        = DIST_SAT;
         dist_max_next        = '0;
         dist_last_next       = DIST_SAT;
      end else begin
         unique case (st.phase)
            PH_PING: begin
               if (sonar_ready && servo_settled) begin
                  cmd.ping_fire      = 1'b1;
                  st_next.ping_angle = servo_angle;
                  st_next.phase      = PH_ECHO;
               end
            end
            PH_ECHO: begin
               if (echo_valid) begin
                  dist_last_next = echo_sat;
                  if (echo_sat < dist_min) begin
                     dist_min_next        = echo_sat;
                     st_next.angle_at_min = st.ping_angle;
                  end
                  if (echo_sat > dist_max) begin
                     dist_max_next        = echo_sat;
                     st_next.angle_at_max = st.ping_angle;
                  end
                  st_next.phase = (st.ping_angle != st.end_angle) ? PH_MOVE : PH_DONE;
               end
            end
            PH_MOVE: begin
               if (servo_angle > st.end_angle) begin
                  cmd.target_valid = 1'b1;
                  cmd.target_angle = ({1'b0, servo_angle} >= down_floor) ?
                                     (servo_angle - st.step_used) : st.end_angle;
               end else if (servo_angle < st.end_angle) begin
                  cmd.target_valid = 1'b1;
                  cmd.target_angle = (up_sum < {1'b0, st.end_angle}) ?
                                     up_sum[ANGLE_BITS-1:0] : st.end_angle;
               end
               st_next.phase = PH_PING;
            end
            default: ;
         endcase
      end
   end

endmodule

[hw/rtl/sonar_sweep_scan_controller.sv]
// Top level of the sonar sweep scan controller.
//
// Usage:
//  - req_bus carries one request per handshake: op=1 starts a scan from the
//    registers, op=0 is a tick with the current sonar/servo status.
//  - rsp_bus returns exactly one result per request, in order: the phase
//    after the request, the ping/target/sensor-reset commands it raised, and
//    the running last/min/max distances with their angles.
//  - csr_* is an APB-style port; five 8-bit registers at byte address 4*i
//    (step, from, to, angle low, angle high). Write only while idle.
// Timing:
//  - Input register loads the request at accept; phase logic runs on the
//    input register and its result is loaded into the result register.
//  - Throughput 1 request per cycle while results are taken; the scan state
//    is updated as the item moves from the input register to the result
//    register, so the next request sees it right away.
// Reset (synchronous, active high): both stages empty, phase idle, step 1,
//  minimum and last distance at saturation, maximum and angles zero.
// Stall: while rsp_bus.ready is low the result holds; one more request is
//  still taken into the input register, then req_bus.ready drops.
module sonar_sweep_scan_controller #(
   parameter int unsigned DISTANCE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sss_req_if.sink                              req_bus,
   sss_rsp_if.source                            rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sss_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [sss_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import sss_pkg::*;

   localparam int unsigned DIST_MASK = (1 << DISTANCE_BITS) - 1;
   localparam logic [DISTANCE_BITS-1:0] DIST_SAT =
      DISTANCE_BITS'((DIST_LIMIT < DIST_MASK) ? DIST_LIMIT : DIST_MASK);

   cfg_type cfg;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic                     op_ff;
   logic                     sonar_ready_ff;
   logic                     servo_settled_ff;
   logic                     echo_valid_ff;
   logic [DISTANCE_BITS-1:0] echo_distance_ff;
   angle_type                servo_angle_ff;

   // scan state
   state_type                st_ff, st_in;
   logic [DISTANCE_BITS-1:0] dist_last_ff, dist_last_in;
   logic [DISTANCE_BITS-1:0] dist_min_ff, dist_min_in;
   logic [DISTANCE_BITS-1:0] dist_max_ff, dist_max_in;
   cmd_type                  cmd;

   // result register
   logic                     out_valid_ff, out_valid_in;
   cmd_type                  cmd_ff;
   logic [PHASE_BITS-1:0]    phase_ff;
   logic [DISTANCE_BITS-1:0] last_distance_ff;
   logic [DISTANCE_BITS-1:0] min_distance_ff;
   logic [DISTANCE_BITS-1:0] max_distance_ff;
   angle_type                min_dist_angle_ff;
   angle_type                max_dist_angle_ff;

   logic req_accept;
   logic advance;

   // ---- configuration ----
   sss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );
   assign csr_pready = 1'b1;

   // ---- handshakes ----
   // advance: the input register hands its request to the result register
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff            <= req_bus.op;
         sonar_ready_ff   <= req_bus.sonar_ready;
         servo_settled_ff <= req_bus.servo_settled;
         echo_valid_ff    <= req_bus.echo_valid;
         echo_distance_ff <= req_bus.echo_distance;
         servo_angle_ff   <= req_bus.servo_angle;
      end
   end

   // ---- phase logic ----
   sss_step #(
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_step (
      .cfg            (cfg),
      .st             (st_ff),
      .dist_last      (dist_last_ff),
      .dist_min       (dist_min_ff),
      .dist_max       (dist_max_ff),
      .op             (op_ff),
      .sonar_ready    (sonar_ready_ff),
      .servo_settled  (servo_settled_ff),
      .echo_valid     (echo_valid_ff),
      .echo_distance  (echo_distance_ff),
      .servo_angle    (servo_angle_ff),
      .st_next        (st_in),
      .dist_last_next (dist_last_in),
      .dist_min_next  (dist_min_in),
      .dist_max_next  (dist_max_in),
      .cmd            (cmd)
   );

   // scan state moves only when a request is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase        <= PH_IDLE;
         st_ff.ping_angle   <= '0;
         st_ff.end_angle    <= '0;
         st_ff.step_used    <= ANGLE_BITS'(1);
         st_ff.angle_at_min <= '0;
         st_ff.angle_at_max <= '0;
         dist_last_ff       <= DIST_SAT;
         dist_min_ff        <= DIST_SAT;
         dist_max_ff        <= '0;
      end else if (advance) begin
         st_ff        <= st_in;
         dist_last_ff <= dist_last_in;
         dist_min_ff  <= dist_min_in;
         dist_max_ff  <= dist_max_in;
      end
   end

   // result register, loaded with the state after the request
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff            <= cmd;
         phase_ff          <= st_in.phase;
         last_distance_ff  <= dist_last_in;
         min_distance_ff   <= dist_min_in;
         max_distance_ff   <= dist_max_in;
         min_dist_angle_ff <= st_in.angle_at_min;
         max_dist_angle_ff <= st_in.angle_at_max;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.phase          = phase_ff;
   assign rsp_bus.ping_fire      = cmd_ff.ping_fire;
   assign rsp_bus.target_valid   = cmd_ff.target_valid;
   assign rsp_bus.target_angle   = cmd_ff.target_angle;
   assign rsp_bus.sensor_reset   = cmd_ff.sensor_reset;
   assign rsp_bus.last_distance  = last_distance_ff;
   assign rsp_bus.min_distance   = min_distance_ff;
   assign rsp_bus.min_dist_angle = min_dist_angle_ff;
   assign rsp_bus.max_distance   = max_distance_ff;
   assign rsp_bus.max_dist_angle = max_dist_angle_ff;
   assign rsp_bus.scan_done      = (phase_ff == PH_DONE);

endmodule

[hw/rtl/sss_checker.sv]
// Port-level checks for the sonar sweep scan controller, bound to the top level.
module sss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] phase,
   input logic       ping_fire,
   input logic       target_valid,
   input logic [7:0] target_angle,
   input logic       sensor_reset,
   input logic       scan_done
);
   import sss_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result right out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // done flag tracks the phase
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (scan_done == (phase == PH_DONE)))
      else $error("scan_done disagrees with phase");

   // a start issues a target and lands in ping
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sensor_reset |-> target_valid && (phase == PH_PING) && !ping_fire)
      else $error("start result malformed");

   // a ping always moves to await echo; no target without target_valid
   a_ping_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!ping_fire || (phase == PH_ECHO && !target_valid)) &&
                    (target_valid || target_angle == '0))
      else $error("ping or target command inconsistent");

endmodule

bind sonar_sweep_scan_controller sss_checker u_sss_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .phase        (rsp_bus.phase),
   .ping_fire    (rsp_bus.ping_fire),
   .target_valid (rsp_bus.target_valid),
   .target_angle (rsp_bus.target_angle),
   .sensor_reset (rsp_bus.sensor_reset),
   .scan_done    (rsp_bus.scan_done)
);
